// ----- rtl/afpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpm_pkg
// Shared types, constants and frame arithmetic helpers for the audio frame
// position map.
// ----------------------------------------------------------------------------
package afpm_pkg;

  // Field widths
  localparam int FRAME_W   = 48;
  localparam int LEN_W     = 40;
  localparam int COUNT_W   = 24;
  localparam int RATIO_W   = 32;
  localparam int BACKLOG_W = 32;
  localparam int EXT_W     = FRAME_W + 2;
  localparam int TOTAL_W   = LEN_W + 2;
  localparam int ENT_W     = 2 * FRAME_W + LEN_W + RATIO_W;

  // Defaults
  localparam int MAX_SEGMENTS_DEF    = 64;
  localparam int RATIO_FRAC_BITS_DEF = 16;
  localparam logic [BACKLOG_W-1:0] BACKLOG_RESET = 32'd441000;

  localparam logic signed [FRAME_W-1:0] FRAME_MAX = {1'b0, {(FRAME_W-1){1'b1}}};
  localparam logic signed [FRAME_W-1:0] FRAME_MIN = {1'b1, {(FRAME_W-1){1'b0}}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [FRAME_W-1:0] source_frame;
    logic [COUNT_W-1:0]        frame_count;
    logic signed [FRAME_W-1:0] dest_start;
    logic [RATIO_W-1:0]        ratio;
  } in_word_t;

  typedef struct packed {
    logic signed [FRAME_W-1:0] mapped_frame;
    logic                      table_empty;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_I_RDL,
    ST_I_LAT,
    ST_I_END,
    ST_I_SCL,
    ST_I_SWAIT,
    ST_I_DEC,
    ST_I_FULL,
    ST_I_APP,
    ST_T_CHK,
    ST_T_ADD,
    ST_S_RDF,
    ST_S_LF,
    ST_S_LL,
    ST_S_END,
    ST_S_CMP,
    ST_S_XSCL,
    ST_S_XWAIT,
    ST_S_SCL,
    ST_S_SWAIT,
    ST_S_OUT,
    ST_S_SCR,
    ST_S_SCLAT,
    ST_S_SCE,
    ST_S_SCC,
    ST_S_GAP,
    ST_S_EMPTY
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_SCAN,
    RD_TRIM
  } rd_sel_e;

  typedef enum logic [1:0] {
    DIFF_LEN,
    DIFF_QF,
    DIFF_QE,
    DIFF_QS
  } diff_sel_e;

  typedef enum logic [1:0] {
    OUT_SUM,
    OUT_BASE,
    OUT_EMPTY
  } out_sel_e;

  typedef struct packed {
    logic      load_in;
    logic      clear_tbl;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      lat_ent;
    logic      lat_first;
    logic      calc_end;
    logic      calc_diff;
    diff_sel_e diff_sel;
    logic      scl_start;
    logic      calc_base;
    logic      base_first;
    logic      base_ent;
    logic      wr_merge;
    logic      drop_old;
    logic      wr_app;
    logic      trim_add;
    logic      trim_fin;
    logic      scan_init;
    logic      scan_next;
    logic      out_load;
    out_sel_e  out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic merge_ok;
    logic trim_more;
    logic q_lt_first;
    logic q_ge_end;
    logic q_in_ent;
    logic scan_last;
    logic scl_done;
    logic out_free;
  } dp_stat_t;

  // Sign-extend a frame to the working width
  function automatic logic signed [EXT_W-1:0] ext_frame(input logic signed [FRAME_W-1:0] f);
    ext_frame = {{(EXT_W-FRAME_W){f[FRAME_W-1]}}, f};
  endfunction

  // Clamp a working-width value to the frame range
  function automatic logic signed [FRAME_W-1:0] sat_frame(input logic signed [EXT_W-1:0] v);
    if ((&v[EXT_W-1:FRAME_W-1]) || !(|v[EXT_W-1:FRAME_W-1])) begin
      sat_frame = v[FRAME_W-1:0];
    end else if (v[EXT_W-1]) begin
      sat_frame = FRAME_MIN;
    end else begin
      sat_frame = FRAME_MAX;
    end
  endfunction

  function automatic logic signed [FRAME_W-1:0] sat_add(input logic signed [FRAME_W-1:0] a,
                                                        input logic signed [FRAME_W-1:0] b);
    sat_add = sat_frame(ext_frame(a) + ext_frame(b));
  endfunction

  function automatic logic signed [FRAME_W-1:0] sat_sub(input logic signed [FRAME_W-1:0] a,
                                                        input logic signed [FRAME_W-1:0] b);
    sat_sub = sat_frame(ext_frame(a) - ext_frame(b));
  endfunction

  function automatic logic signed [FRAME_W-1:0] sat_add_len(input logic signed [FRAME_W-1:0] a,
                                                            input logic [LEN_W-1:0] len);
    sat_add_len = sat_frame(ext_frame(a) + $signed({{(EXT_W-LEN_W){1'b0}}, len}));
  endfunction

endpackage

// ----- rtl/afpm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/afpm_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpm_scale
// Multi-cycle frame scaler: signed frames times unsigned fixed-point ratio,
// rounded half away from zero and clamped to the frame range.
// One 32x32 multiplier serves the low half of the magnitude and then the high half.
// ----------------------------------------------------------------------------
module afpm_scale #(
  parameter int RATIO_FRAC_BITS = afpm_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [afpm_pkg::FRAME_W-1:0] x_i,
  input  logic [afpm_pkg::RATIO_W-1:0]        ratio_i,
  output logic                                done_o,
  output logic signed [afpm_pkg::FRAME_W-1:0] res_o
);

  localparam int FW = afpm_pkg::FRAME_W;
  localparam int PW = FW + 32;
  localparam logic [PW-1:0] HALF = PW'(1) << (RATIO_FRAC_BITS - 1);

  logic [3:0]                  stg_q;
  logic                        done_q;
  logic                        neg_q;
  logic [FW-1:0]               m_q;
  logic [afpm_pkg::RATIO_W-1:0] r_q;
  logic [63:0]                 plo_q;
  logic [FW-1:0]               phi_q;
  logic [FW-1:0]               qs_q;
  logic signed [FW-1:0]        res_q;
  logic [PW-1:0]               full;
  logic [PW-1:0]               quot;
  logic [FW-1:0]               lim;
  logic [31:0]                 mul_a;
  logic [63:0]                 mul_p;

  // Share one multiplier: low half of the magnitude first, then the high half
  always_comb begin
    mul_a = stg_q[0] ? m_q[31:0] : 32'(m_q[FW-1:32]);
    mul_p = mul_a * r_q;
  end

  // Round, shift and clamp the magnitude
  always_comb begin
    full = {phi_q, 32'd0} + PW'(plo_q) + HALF;
    quot = full >> RATIO_FRAC_BITS;
    lim  = neg_q ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
  end

  // Stage tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q  <= '0;
      done_q <= 1'b0;
    end else begin
      stg_q  <= {stg_q[2:0], start_i};
      done_q <= stg_q[3];
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= x_i[FW-1];
      m_q   <= x_i[FW-1] ? FW'(-x_i) : FW'(x_i);
      r_q   <= ratio_i;
    end
    if (stg_q[0]) begin
      plo_q <= mul_p;
    end
    if (stg_q[1]) begin
      phi_q <= mul_p[FW-1:0];
    end
    if (stg_q[2]) begin
      qs_q <= (quot >= PW'(lim)) ? lim : quot[FW-1:0];
    end
    if (stg_q[3]) begin
      res_q <= neg_q ? $signed(-qs_q) : $signed(qs_q);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- rtl/afpm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpm_datapath
// Segment table storage, table pointers, frame arithmetic, trim accumulator
// and result register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module afpm_datapath #(
  parameter int MAX_SEGMENTS    = afpm_pkg::MAX_SEGMENTS_DEF,
  parameter int RATIO_FRAC_BITS = afpm_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  afpm_pkg::in_word_t              in_data_i,
  input  logic                            cfg_we_i,
  input  logic [afpm_pkg::BACKLOG_W-1:0]  cfg_wdata_i,
  input  afpm_pkg::ctrl_cmd_t             cmd_i,
  output afpm_pkg::dp_stat_t              stat_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output afpm_pkg::out_word_t             out_data_o
);

  localparam int FW = afpm_pkg::FRAME_W;
  localparam int LW = afpm_pkg::LEN_W;
  localparam int RW = afpm_pkg::RATIO_W;
  localparam int EW = afpm_pkg::EXT_W;
  localparam int TW = afpm_pkg::TOTAL_W;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = CW + 1;

  // Wrap a table position onto a storage slot
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(k);
    if (s >= SW'(MAX_SEGMENTS)) begin
      s = s - SW'(MAX_SEGMENTS);
    end
    slot = s[IW-1:0];
  endfunction

  afpm_pkg::in_word_t          in_q;
  logic [IW-1:0]               oldest_q, oldest_d;
  logic [CW-1:0]               count_q, count_d;
  logic [afpm_pkg::BACKLOG_W-1:0] backlog_q;
  logic signed [FW-1:0]        ent_start_q, ent_dst_q;
  logic [LW-1:0]               ent_len_q;
  logic [RW-1:0]               ent_ratio_q;
  logic signed [FW-1:0]        f_start_q, f_dst_q;
  logic [RW-1:0]               f_ratio_q;
  logic signed [FW-1:0]        end_q;
  logic signed [FW-1:0]        diff_q;
  logic [RW-1:0]               dratio_q;
  logic signed [FW-1:0]        base_q;
  logic [TW-1:0]               total_q;
  logic [CW-1:0]               kept_q;
  logic [CW-1:0]               scan_q;
  logic                        out_valid_q;
  afpm_pkg::out_word_t         out_q;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  logic [afpm_pkg::ENT_W-1:0]  ram_wdata, ram_rdata;
  logic signed [FW-1:0]        rd_start, rd_dst;
  logic [LW-1:0]               rd_len;
  logic [RW-1:0]               rd_ratio;
  logic                        scl_done;
  logic signed [FW-1:0]        scl_res;
  logic [LW:0]                 merge_sum;
  logic [LW-1:0]               merge_len;
  logic signed [EW-1:0]        dest_gap;
  logic [IW-1:0]               last_slot;
  logic [CW-1:0]               trim_k;

  // Split a stored entry
  assign rd_start = ram_rdata[afpm_pkg::ENT_W-1 -: FW];
  assign rd_dst   = ram_rdata[afpm_pkg::ENT_W-FW-1 -: FW];
  assign rd_len   = ram_rdata[RW+LW-1 -: LW];
  assign rd_ratio = ram_rdata[RW-1:0];

  assign last_slot = slot(oldest_q, count_q - CW'(1));
  assign trim_k    = count_q - kept_q - CW'(1);

  // Read address
  always_comb begin
    case (cmd_i.rd_sel)
      afpm_pkg::RD_FIRST: ram_raddr = oldest_q;
      afpm_pkg::RD_LAST:  ram_raddr = last_slot;
      afpm_pkg::RD_SCAN:  ram_raddr = slot(oldest_q, scan_q);
      default:            ram_raddr = slot(oldest_q, trim_k);
    endcase
  end

  // Merge length, saturated
  assign merge_sum = {1'b0, ent_len_q} + (LW + 1)'(in_q.frame_count);
  assign merge_len = merge_sum[LW] ? afpm_pkg::LEN_MAX : merge_sum[LW-1:0];

  // Write port: extend newest entry or append a new one
  always_comb begin
    ram_we = cmd_i.wr_merge | cmd_i.wr_app;
    if (cmd_i.wr_merge) begin
      ram_waddr = last_slot;
      ram_wdata = {ent_start_q, ent_dst_q, merge_len, ent_ratio_q};
    end else begin
      ram_waddr = slot(oldest_q, count_q);
      ram_wdata = {in_q.source_frame, in_q.dest_start, LW'(in_q.frame_count), in_q.ratio};
    end
  end

  afpm_ram #(
    .WIDTH (afpm_pkg::ENT_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  afpm_scale #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.scl_start),
    .x_i     (diff_q),
    .ratio_i (dratio_q),
    .done_o  (scl_done),
    .res_o   (scl_res)
  );

  // Table pointers
  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    if (cmd_i.clear_tbl) begin
      oldest_d = '0;
      count_d  = '0;
    end
    if (cmd_i.drop_old && (count_q == CW'(MAX_SEGMENTS))) begin
      oldest_d = slot(oldest_q, CW'(1));
      count_d  = CW'(MAX_SEGMENTS - 1);
    end
    if (cmd_i.wr_app) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.trim_fin) begin
      oldest_d = slot(oldest_q, count_q - kept_q);
      count_d  = kept_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      count_q     <= '0;
      backlog_q   <= afpm_pkg::BACKLOG_RESET;
      kept_q      <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
      if (cfg_we_i) begin
        backlog_q <= cfg_wdata_i;
      end
      // Restart the trim walk with each table write
      if (cmd_i.wr_merge || cmd_i.wr_app) begin
        kept_q <= '0;
      end else if (cmd_i.trim_add) begin
        kept_q <= kept_q + CW'(1);
      end
      if (cmd_i.scan_init) begin
        scan_q <= '0;
      end else if (cmd_i.scan_next) begin
        scan_q <= scan_q + CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.lat_ent) begin
      ent_start_q <= rd_start;
      ent_dst_q   <= rd_dst;
      ent_len_q   <= rd_len;
      ent_ratio_q <= rd_ratio;
    end
    if (cmd_i.lat_first) begin
      f_start_q <= ent_start_q;
      f_dst_q   <= ent_dst_q;
      f_ratio_q <= ent_ratio_q;
    end
    if (cmd_i.calc_end) begin
      end_q <= afpm_pkg::sat_add_len(ent_start_q, ent_len_q);
    end
    // Scaler operand
    if (cmd_i.calc_diff) begin
      case (cmd_i.diff_sel)
        afpm_pkg::DIFF_LEN: begin
          diff_q   <= $signed(FW'(ent_len_q));
          dratio_q <= ent_ratio_q;
        end
        afpm_pkg::DIFF_QF: begin
          diff_q   <= afpm_pkg::sat_sub(in_q.source_frame, f_start_q);
          dratio_q <= f_ratio_q;
        end
        afpm_pkg::DIFF_QE: begin
          diff_q   <= afpm_pkg::sat_sub(in_q.source_frame, end_q);
          dratio_q <= ent_ratio_q;
        end
        default: begin
          diff_q   <= afpm_pkg::sat_sub(in_q.source_frame, ent_start_q);
          dratio_q <= ent_ratio_q;
        end
      endcase
    end
    // Destination base
    if (cmd_i.calc_base) begin
      base_q <= afpm_pkg::sat_add(ent_dst_q, scl_res);
    end else if (cmd_i.base_first) begin
      base_q <= f_dst_q;
    end else if (cmd_i.base_ent) begin
      base_q <= ent_dst_q;
    end
    // Trim accumulator
    if (cmd_i.wr_merge || cmd_i.wr_app) begin
      total_q <= '0;
    end else if (cmd_i.trim_add) begin
      total_q <= total_q + TW'(rd_len);
    end
    // Result word
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        afpm_pkg::OUT_SUM: begin
          out_q.mapped_frame <= afpm_pkg::sat_add(base_q, scl_res);
          out_q.table_empty  <= 1'b0;
        end
        afpm_pkg::OUT_BASE: begin
          out_q.mapped_frame <= base_q;
          out_q.table_empty  <= 1'b0;
        end
        default: begin
          out_q.mapped_frame <= '0;
          out_q.table_empty  <= 1'b1;
        end
      endcase
    end
  end

  // Status toward the controller
  assign dest_gap = afpm_pkg::ext_frame(base_q) - afpm_pkg::ext_frame(in_q.dest_start);

  always_comb begin
    stat_o.count_zero = (count_q == '0);
    stat_o.merge_ok   = (end_q == in_q.source_frame) && (ent_ratio_q == in_q.ratio) &&
                        ((dest_gap == EW'(0)) || (dest_gap == EW'(1)) ||
                         (dest_gap == {EW{1'b1}}));
    stat_o.trim_more  = (total_q < TW'(backlog_q)) && (kept_q < count_q);
    stat_o.q_lt_first = (in_q.source_frame < f_start_q);
    stat_o.q_ge_end   = (in_q.source_frame >= end_q);
    stat_o.q_in_ent   = (in_q.source_frame >= ent_start_q) && (in_q.source_frame < end_q);
    stat_o.scan_last  = (scan_q == count_q - CW'(1));
    stat_o.scl_done   = scl_done;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/afpm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afpm_ctrl
// Sequencer for insert, trim, search and clear; issues datapath commands.
// ----------------------------------------------------------------------------
module afpm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          op_i,
  output logic                in_stall_o,
  input  afpm_pkg::dp_stat_t  stat_i,
  output afpm_pkg::ctrl_cmd_t cmd_o
);

  afpm_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afpm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != afpm_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      afpm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          unique case (op_i)
            afpm_pkg::OP_INSERT:
              state_d = stat_i.count_zero ? afpm_pkg::ST_I_FULL : afpm_pkg::ST_I_RDL;
            afpm_pkg::OP_SEARCH:
              state_d = stat_i.count_zero ? afpm_pkg::ST_S_EMPTY : afpm_pkg::ST_S_RDF;
            afpm_pkg::OP_CLEAR:
              cmd_o.clear_tbl = 1'b1;
            default: ;
          endcase
        end
      end
      // Insert: fetch the newest segment and test for a merge
      afpm_pkg::ST_I_RDL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = afpm_pkg::RD_LAST;
        state_d      = afpm_pkg::ST_I_LAT;
      end
      afpm_pkg::ST_I_LAT: begin
        cmd_o.lat_ent = 1'b1;
        state_d       = afpm_pkg::ST_I_END;
      end
      afpm_pkg::ST_I_END: begin
        cmd_o.calc_end  = 1'b1;
        cmd_o.calc_diff = 1'b1;
        cmd_o.diff_sel  = afpm_pkg::DIFF_LEN;
        state_d         = afpm_pkg::ST_I_SCL;
      end
      afpm_pkg::ST_I_SCL: begin
        cmd_o.scl_start = 1'b1;
        state_d         = afpm_pkg::ST_I_SWAIT;
      end
      afpm_pkg::ST_I_SWAIT: begin
        if (stat_i.scl_done) begin
          cmd_o.calc_base = 1'b1;
          state_d         = afpm_pkg::ST_I_DEC;
        end
      end
      afpm_pkg::ST_I_DEC: begin
        if (stat_i.merge_ok) begin
          cmd_o.wr_merge = 1'b1;
          state_d        = afpm_pkg::ST_T_CHK;
        end else begin
          state_d = afpm_pkg::ST_I_FULL;
        end
      end
      afpm_pkg::ST_I_FULL: begin
        cmd_o.drop_old = 1'b1;
        state_d        = afpm_pkg::ST_I_APP;
      end
      afpm_pkg::ST_I_APP: begin
        cmd_o.wr_app = 1'b1;
        state_d      = afpm_pkg::ST_T_CHK;
      end
      // Trim: walk from the newest segment until the backlog is covered
      afpm_pkg::ST_T_CHK: begin
        if (stat_i.trim_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = afpm_pkg::RD_TRIM;
          state_d      = afpm_pkg::ST_T_ADD;
        end else begin
          cmd_o.trim_fin = 1'b1;
          state_d        = afpm_pkg::ST_IDLE;
        end
      end
      afpm_pkg::ST_T_ADD: begin
        cmd_o.trim_add = 1'b1;
        state_d        = afpm_pkg::ST_T_CHK;
      end
      // Search: fetch first and last segments
      afpm_pkg::ST_S_RDF: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = afpm_pkg::RD_FIRST;
        state_d      = afpm_pkg::ST_S_LF;
      end
      afpm_pkg::ST_S_LF: begin
        cmd_o.lat_ent = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = afpm_pkg::RD_LAST;
        state_d       = afpm_pkg::ST_S_LL;
      end
      afpm_pkg::ST_S_LL: begin
        cmd_o.lat_first = 1'b1;
        cmd_o.lat_ent   = 1'b1;
        state_d         = afpm_pkg::ST_S_END;
      end
      afpm_pkg::ST_S_END: begin
        cmd_o.calc_end = 1'b1;
        state_d        = afpm_pkg::ST_S_CMP;
      end
      afpm_pkg::ST_S_CMP: begin
        if (stat_i.q_lt_first) begin
          cmd_o.calc_diff  = 1'b1;
          cmd_o.diff_sel   = afpm_pkg::DIFF_QF;
          cmd_o.base_first = 1'b1;
          state_d          = afpm_pkg::ST_S_SCL;
        end else if (stat_i.q_ge_end) begin
          cmd_o.calc_diff = 1'b1;
          cmd_o.diff_sel  = afpm_pkg::DIFF_LEN;
          state_d         = afpm_pkg::ST_S_XSCL;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = afpm_pkg::ST_S_SCR;
        end
      end
      // Past the end: scale the last segment's length first
      afpm_pkg::ST_S_XSCL: begin
        cmd_o.scl_start = 1'b1;
        state_d         = afpm_pkg::ST_S_XWAIT;
      end
      afpm_pkg::ST_S_XWAIT: begin
        if (stat_i.scl_done) begin
          cmd_o.calc_base = 1'b1;
          cmd_o.calc_diff = 1'b1;
          cmd_o.diff_sel  = afpm_pkg::DIFF_QE;
          state_d         = afpm_pkg::ST_S_SCL;
        end
      end
      afpm_pkg::ST_S_SCL: begin
        cmd_o.scl_start = 1'b1;
        state_d         = afpm_pkg::ST_S_SWAIT;
      end
      afpm_pkg::ST_S_SWAIT: begin
        if (stat_i.scl_done) begin
          state_d = afpm_pkg::ST_S_OUT;
        end
      end
      afpm_pkg::ST_S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = afpm_pkg::OUT_SUM;
          state_d        = afpm_pkg::ST_IDLE;
        end
      end
      // Inside the span: walk segments oldest first
      afpm_pkg::ST_S_SCR: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = afpm_pkg::RD_SCAN;
        state_d      = afpm_pkg::ST_S_SCLAT;
      end
      afpm_pkg::ST_S_SCLAT: begin
        cmd_o.lat_ent = 1'b1;
        state_d       = afpm_pkg::ST_S_SCE;
      end
      afpm_pkg::ST_S_SCE: begin
        cmd_o.calc_end = 1'b1;
        state_d        = afpm_pkg::ST_S_SCC;
      end
      afpm_pkg::ST_S_SCC: begin
        if (stat_i.q_in_ent) begin
          cmd_o.calc_diff = 1'b1;
          cmd_o.diff_sel  = afpm_pkg::DIFF_QS;
          cmd_o.base_ent  = 1'b1;
          state_d         = afpm_pkg::ST_S_SCL;
        end else if (stat_i.scan_last) begin
          cmd_o.base_first = 1'b1;
          state_d          = afpm_pkg::ST_S_GAP;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = afpm_pkg::ST_S_SCR;
        end
      end
      afpm_pkg::ST_S_GAP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = afpm_pkg::OUT_BASE;
          state_d        = afpm_pkg::ST_IDLE;
        end
      end
      afpm_pkg::ST_S_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = afpm_pkg::OUT_EMPTY;
          state_d        = afpm_pkg::ST_IDLE;
        end
      end
      default: state_d = afpm_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/audio_frame_position_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_frame_position_map
// Segment table mapping source audio frames to destination frames.
// ----------------------------------------------------------------------------
// One word is taken at a time; the input stalls until its work is done, while
// a finished search result may still wait in the output register. Clear and
// the unused operation code are done in the idle state that takes them. The
// time of an insert grows with the segments kept by the trim, set by the walk
// over the single-read table memory. The time of a search depends on whether
// the frame lies before the first segment, after the last or inside the span,
// where it grows with the segments walked; each scaling runs in a unit that
// shares one 32x32 multiplier between the two halves of the magnitude. The
// table memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module audio_frame_position_map #(
  parameter int MAX_SEGMENTS    = afpm_pkg::MAX_SEGMENTS_DEF,
  parameter int RATIO_FRAC_BITS = afpm_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  afpm_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output afpm_pkg::out_word_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [afpm_pkg::BACKLOG_W-1:0] cfg_wdata_i
);

  afpm_pkg::ctrl_cmd_t cmd;
  afpm_pkg::dp_stat_t  stat;

  afpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (in_data_i.operation),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  afpm_datapath #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for audio_frame_position_map. Words go in through a
// bursty sender. A local model of the segment table predicts each search
// answer, and a checker compares every answer that leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  import afpm_pkg::*;

  localparam int      SEGS      = 64;
  localparam int      CYC_LIMIT = 3000000;
  localparam int      HOLD_CYC  = 400;
  localparam int      SETTLE    = 300;
  localparam longint  F_HI      = (64'sd1 <<< 47) - 1;
  localparam longint  F_LO      = -(64'sd1 <<< 47);
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [31:0] UNITY     = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int errors = 0;
  int cycles = 0;
  out_word_t mapped_q[$];

  // Segment table copy kept by the bench
  longint      seg_src[SEGS];
  longint      seg_dst[SEGS];
  logic [39:0] seg_len[SEGS];
  logic [31:0] seg_rat[SEGS];
  int          oldest = 0;
  int          n_seg = 0;
  logic [31:0] backlog = BACKLOG_RESET;

  // Sender and receiver pacing
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int stall_mode = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  audio_frame_position_map DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("audio_frame_position_map verification failed");
      $finish;
    end
  end

  // ---------------- frame arithmetic ----------------
  function automatic longint clampf(longint v);
    if (v > F_HI) return F_HI;
    if (v < F_LO) return F_LO;
    return v;
  endfunction

  function automatic longint sext(logic [47:0] f);
    return longint'({{16{f[47]}}, f});
  endfunction

  // Q16.16 scaling, half away from zero, saturating
  function automatic longint scale_frames(longint f, logic [31:0] r);
    bit          neg;
    logic [95:0] mag;
    logic [95:0] q;
    logic [95:0] lim;
    neg = f < 0;
    mag = neg ? 96'(-f) : 96'(f);
    q   = (mag * {64'd0, r} + 96'd32768) >> 16;
    lim = neg ? 96'(64'd1 << 47) : 96'(F_HI);
    if (q >= lim) return neg ? F_LO : F_HI;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic int slot(int k);
    return (oldest + k) % SEGS;
  endfunction

  function automatic longint src_end(int s);
    return clampf(seg_src[s] + longint'(seg_len[s]));
  endfunction

  function automatic longint dst_end(int s);
    return clampf(seg_dst[s] + scale_frames(longint'(seg_len[s]), seg_rat[s]));
  endfunction

  // Merge into the newest segment or append, then trim to the backlog
  function automatic void map_insert(longint src, logic [39:0] len, longint dst,
                                     logic [31:0] r);
    bit          merged;
    logic [63:0] total;
    int          kept;
    int          s;
    longint      diff;
    logic [40:0] nl;
    merged = 1'b0;
    total  = '0;
    kept   = 0;
    if (n_seg > 0) begin
      s = slot(n_seg - 1);
      diff = dst_end(s) - dst;
      if (diff < 0) diff = -diff;
      if (src_end(s) == src && seg_rat[s] == r && diff <= 1) begin
        nl = {1'b0, seg_len[s]} + {1'b0, len};
        seg_len[s] = nl[40] ? LEN_MAX : nl[39:0];
        merged = 1'b1;
      end
    end
    if (!merged) begin
      if (n_seg >= SEGS) begin
        oldest = (oldest + 1) % SEGS;
        n_seg = SEGS - 1;
      end
      s = slot(n_seg);
      seg_src[s] = src;
      seg_dst[s] = dst;
      seg_len[s] = len;
      seg_rat[s] = r;
      n_seg++;
    end
    while (total < {32'd0, backlog} && kept < n_seg) begin
      kept++;
      total += {24'd0, seg_len[slot(n_seg - kept)]};
    end
    oldest = slot(n_seg - kept);
    n_seg = kept;
  endfunction

  function automatic longint map_lookup(longint q);
    int     f;
    int     l;
    int     s;
    longint st;
    f = slot(0);
    l = slot(n_seg - 1);
    if (q < seg_src[f])
      return clampf(seg_dst[f] + scale_frames(clampf(q - seg_src[f]), seg_rat[f]));
    if (q >= src_end(l))
      return clampf(dst_end(l) + scale_frames(clampf(q - src_end(l)), seg_rat[l]));
    for (int k = 0; k < n_seg; k++) begin
      s = slot(k);
      st = seg_src[s];
      if (q >= st && q < src_end(s))
        return clampf(seg_dst[s] + scale_frames(clampf(q - st), seg_rat[s]));
    end
    return seg_dst[f];
  endfunction

  // Apply one accepted word to the table copy
  function automatic void apply_word(in_word_t w);
    out_word_t res;
    case (w.operation)
      OP_INSERT: begin
        map_insert(sext(w.source_frame), {16'd0, w.frame_count}, sext(w.dest_start),
                   w.ratio);
      end
      OP_SEARCH: begin
        if (n_seg == 0) begin
          res.mapped_frame = '0;
          res.table_empty  = 1'b1;
        end else begin
          res.mapped_frame = 48'(map_lookup(sext(w.source_frame)));
          res.table_empty  = 1'b0;
        end
        mapped_q.push_back(res);
      end
      OP_CLEAR: begin
        oldest = 0;
        n_seg = 0;
      end
      default: ;
    endcase
  endfunction

  // ---------------- sender ----------------
  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    apply_word(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  function automatic in_word_t mk(logic [1:0] op, longint src, int unsigned cnt,
                                  longint dst, logic [31:0] r);
    in_word_t w;
    w.operation    = op;
    w.source_frame = 48'(src);
    w.frame_count  = 24'(cnt);
    w.dest_start   = 48'(dst);
    w.ratio        = r;
    return w;
  endfunction

  // Let the block finish, then write the backlog register
  task automatic set_backlog(logic [31:0] v);
    in_valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    backlog = v;
  endtask

  function automatic logic [47:0] rnd48();
    return {16'($urandom), $urandom};
  endfunction

  // Next word of the random stream, mostly continuing the newest segment
  function automatic in_word_t next_word();
    int          pick;
    longint      nsrc;
    longint      ndst;
    logic [31:0] r;
    longint      span;
    pick = $urandom_range(0, 99);
    nsrc = 0;
    ndst = 0;
    r    = UNITY;
    if (n_seg > 0) begin
      nsrc = src_end(slot(n_seg - 1));
      ndst = dst_end(slot(n_seg - 1));
      r    = seg_rat[slot(n_seg - 1)];
    end
    if (pick < 50) begin
      if ($urandom_range(0, 4) == 0) r = UNITY + 32'($urandom_range(0, 8192)) - 32'd4096;
      if ($urandom_range(0, 5) == 0) nsrc += $urandom_range(1, 500);
      ndst += longint'($urandom_range(0, 4)) - 2;
      return mk(OP_INSERT, nsrc, $urandom_range(1, 3000), ndst, r);
    end else if (pick < 82) begin
      span = n_seg > 0 ? nsrc - seg_src[slot(0)] + 2000 : 1000;
      return mk(OP_SEARCH, nsrc - longint'($urandom_range(0, 32'(span))) + 1000,
                0, 48'($urandom), $urandom);
    end else if (pick < 86) begin
      return mk(OP_CLEAR, sext(rnd48()), $urandom, sext(rnd48()), $urandom);
    end else if (pick < 88) begin
      return mk(OP_UNUSED, sext(rnd48()), $urandom, sext(rnd48()), $urandom);
    end else if (pick < 94) begin
      return mk(OP_INSERT, sext(rnd48()), $urandom, sext(rnd48()), $urandom);
    end
    return mk(OP_SEARCH, sext(rnd48()), $urandom, sext(rnd48()), $urandom);
  endfunction

  // ---------------- receiver ----------------
  // Hold off on request, otherwise stall by the current pattern
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYC;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 127) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Compare each answer with the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (mapped_q.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
      end else begin
        want = mapped_q.pop_front();
        if (out_data.mapped_frame !== want.mapped_frame) begin
          errors <= errors + 1;
          $display("%0t: mapped_frame expected %0d actual %0d", $time,
                   want.mapped_frame, out_data.mapped_frame);
        end
        if (out_data.table_empty !== want.table_empty) begin
          errors <= errors + 1;
          $display("%0t: table_empty expected %b actual %b", $time,
                   want.table_empty, out_data.table_empty);
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_word(mk(OP_SEARCH, 5, 0, 0, 0));
    send_word(mk(OP_UNUSED, -1, 24'hFFFFFF, -1, '1));
    send_word(mk(OP_INSERT, 0, 100, 0, UNITY));
    // continues within one frame: merges
    send_word(mk(OP_INSERT, 100, 50, 101, UNITY));
    // leaves a gap from 150 to 200
    send_word(mk(OP_INSERT, 200, 50, 500, 32'h0002_0000));
    send_word(mk(OP_SEARCH, 170, 0, 0, 0));
    send_word(mk(OP_SEARCH, -50, 0, 0, 0));
    send_word(mk(OP_SEARCH, 1000, 0, 0, 0));
    send_word(mk(OP_SEARCH, 120, 0, 0, 0));
    send_word(mk(OP_SEARCH, 149, 0, 0, 0));
    // saturating extremes
    send_word(mk(OP_INSERT, F_HI - 10, 24'hFFFFFF, F_HI, 32'hFFFF_FFFF));
    send_word(mk(OP_SEARCH, F_HI, 0, 0, 0));
    send_word(mk(OP_SEARCH, F_LO, 0, 0, 0));
    send_word(mk(OP_INSERT, F_LO, 0, F_LO, 32'd0));
    send_word(mk(OP_SEARCH, 0, 0, 0, 0));
    send_word(mk(OP_SEARCH, F_LO, 0, 0, 0));
    send_word(mk(OP_INSERT, -1000, 3, F_LO, 32'h8000_0001));
    send_word(mk(OP_SEARCH, F_HI, 0, 0, 0));
    send_word(mk(OP_CLEAR, 0, 0, 0, 0));
    send_word(mk(OP_SEARCH, 7, 0, 0, 0));
  endtask

  task automatic test_backlog_extremes();
    // zero backlog empties the table on every insert
    set_backlog(32'd0);
    send_word(mk(OP_INSERT, 10, 10, 10, UNITY));
    send_word(mk(OP_SEARCH, 12, 0, 0, 0));
    // full table drops the oldest segment
    set_backlog(32'hFFFF_FFFF);
    for (int i = 0; i < 70; i++)
      send_word(mk(OP_INSERT, i * 1000, 100, i * 3000, UNITY + 32'(i)));
    send_word(mk(OP_SEARCH, 0, 0, 0, 0));
    send_word(mk(OP_SEARCH, 6050, 0, 0, 0));
    send_word(mk(OP_SEARCH, 69050, 0, 0, 0));
    send_word(mk(OP_SEARCH, 68500, 0, 0, 0));
    send_word(mk(OP_CLEAR, 0, 0, 0, 0));
  endtask

  task automatic test_random_stream();
    logic [31:0] settings[4] = '{32'd5000, 32'd1, 32'd40000, BACKLOG_RESET};
    for (int p = 0; p < 4; p++) begin
      set_backlog(settings[p]);
      gaps_on = (p != 2);
      for (int i = 0; i < 330; i++) send_word(next_word());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    hold_req++;
    for (int i = 0; i < 40; i++)
      send_word(mk(OP_SEARCH, longint'($urandom_range(0, 200000)), 0, 0, 0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backlog_extremes();
    test_output_backpressure();
    test_random_stream();
    in_valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && mapped_q.size() == 0) begin
      $display("audio_frame_position_map verification clean");
    end else begin
      $display("audio_frame_position_map verification failed");
    end
    $finish;
  end

endmodule
